// File: rtl/core/pax_pkg.sv
// Package for the point axis rotator: shared constants, codes and the sine table builder.
package pax_pkg;

  // Field widths and parameter defaults
  localparam int unsigned COORD_WIDTH_DEF    = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 14;
  localparam int unsigned ANGLE_WIDTH        = 9;

  // Axis codes held in the configuration register
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Angle landmarks in degrees, at the width of the angle field
  localparam logic [ANGLE_WIDTH-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_WIDTH-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_WIDTH-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_WIDTH-1:0] DEG_360 = 9'd360;

  // Quarter-wave table: entries 0..90 degrees
  localparam int unsigned QTAB_LAST = 90;
  localparam int unsigned QIDX_W    = $clog2(QTAB_LAST + 1);

  // Series evaluation constants, unsigned Q1.31 work format
  localparam int unsigned     WORK_BITS    = 31;
  localparam longint unsigned PI_WORK      = 64'd6746518852;
  localparam int unsigned     SERIES_TERMS = 10;

  typedef longint unsigned qtab_t [0:QTAB_LAST];

  // Rounded Q1.31 product
  function automatic longint unsigned mul_work(input longint unsigned a,
                                               input longint unsigned b);
    return (a * b + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
  endfunction

  // Build sin(d) for d = 0..90 degrees with frac_bits fraction bits (elaboration only)
  function automatic qtab_t quarter_table(input int unsigned frac_bits);
    qtab_t           t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned half;
    longint unsigned dd;
    longint unsigned prod;
    longint          sum;
    half = 64'd1 << (WORK_BITS - frac_bits - 1);
    for (int d = 0; d <= QTAB_LAST; d++) begin
      dd   = longint'(d);
      x    = (dd * PI_WORK + 64'd90) / 64'd180;
      x2   = mul_work(x, x);
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= SERIES_TERMS; k++) begin
        prod = mul_work(term, x2);
        // Series divisor (2k)(2k+1) for each term
        case (k)
          1:       term = prod / 64'd6;
          2:       term = prod / 64'd20;
          3:       term = prod / 64'd42;
          4:       term = prod / 64'd72;
          5:       term = prod / 64'd110;
          6:       term = prod / 64'd156;
          7:       term = prod / 64'd210;
          8:       term = prod / 64'd272;
          9:       term = prod / 64'd342;
          10:      term = prod / 64'd420;
          default: term = '0;
        endcase
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      t[d] = (longint'(sum) + half) >> (WORK_BITS - frac_bits);
    end
    return t;
  endfunction

endpackage

// File: rtl/core/pax_cfg_if.sv
// Configuration write channel: one axis-select register.
interface pax_cfg_if;
  logic valid;
  logic ready;
  logic rotation_axis;

  modport source (output valid, output rotation_axis, input ready);
  modport sink   (input valid, input rotation_axis, output ready);
endinterface

// File: rtl/core/pax_point_if.sv
// Input point channel: coordinates and rotation angle.
interface pax_point_if #(
  parameter int unsigned COORD_WIDTH = pax_pkg::COORD_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_WIDTH-1:0]       in_x;
  logic signed [COORD_WIDTH-1:0]       in_y;
  logic signed [COORD_WIDTH-1:0]       in_z;
  logic [pax_pkg::ANGLE_WIDTH-1:0]     angle_deg;

  modport source (output valid, output in_x, output in_y, output in_z, output angle_deg,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input angle_deg,
                  output ready);
endinterface

// File: rtl/core/pax_result_if.sv
// Result channel: rotated coordinates and clip flag.
interface pax_result_if #(
  parameter int unsigned COORD_WIDTH = pax_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output saturated,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input saturated,
                  output ready);
endinterface

// File: rtl/core/pax_trig.sv
// Sine and cosine lookup for a whole-degree angle from a quarter-wave table.
module pax_trig #(
  parameter int unsigned TRIG_FRAC_BITS = pax_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic [pax_pkg::ANGLE_WIDTH-1:0]    angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   nsin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_o
);
  import pax_pkg::*;

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam qtab_t QTAB = quarter_table(TRIG_FRAC_BITS);

  logic [ANGLE_WIDTH-1:0] ang;
  logic [ANGLE_WIDTH-1:0] sin_idx_w;
  logic [ANGLE_WIDTH-1:0] cos_idx_w;
  logic                   sin_neg;
  logic                   cos_neg;
  logic [QIDX_W-1:0]      sin_idx;
  logic [QIDX_W-1:0]      cos_idx;
  logic signed [TW-1:0]   sin_mag;
  logic signed [TW-1:0]   cos_mag;

  // Wrap angles of 360 and above back into one turn
  assign ang = (angle_i >= DEG_360) ? (angle_i - DEG_360) : angle_i;

  // Fold the angle into the first quadrant for both functions
  always_comb begin
    if (ang <= DEG_90) begin
      sin_idx_w = ang;
      sin_neg   = 1'b0;
      cos_idx_w = DEG_90 - ang;
      cos_neg   = 1'b0;
    end else if (ang <= DEG_180) begin
      sin_idx_w = DEG_180 - ang;
      sin_neg   = 1'b0;
      cos_idx_w = ang - DEG_90;
      cos_neg   = 1'b1;
    end else if (ang <= DEG_270) begin
      sin_idx_w = ang - DEG_180;
      sin_neg   = 1'b1;
      cos_idx_w = DEG_270 - ang;
      cos_neg   = 1'b1;
    end else begin
      sin_idx_w = DEG_360 - ang;
      sin_neg   = 1'b1;
      cos_idx_w = ang - DEG_270;
      cos_neg   = 1'b0;
    end
  end

  assign sin_idx = sin_idx_w[QIDX_W-1:0];
  assign cos_idx = cos_idx_w[QIDX_W-1:0];

  // Look up magnitudes and apply quadrant signs
  assign sin_mag = TW'(QTAB[sin_idx]);
  assign cos_mag = TW'(QTAB[cos_idx]);

  assign sin_o  = sin_neg ? -sin_mag : sin_mag;
  assign nsin_o = sin_neg ? sin_mag : -sin_mag;
  assign cos_o  = cos_neg ? -cos_mag : cos_mag;

endmodule

// File: rtl/core/pax_rot_lane.sv
// One rotated coordinate: a*ca + b*cb, rounded to nearest and saturated.
module pax_rot_lane #(
  parameter int unsigned COORD_WIDTH    = pax_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = pax_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic signed [COORD_WIDTH-1:0]      a_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]   ca_i,
  input  logic signed [COORD_WIDTH-1:0]      b_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]   cb_i,
  output logic signed [COORD_WIDTH-1:0]      res_o,
  output logic                               clip_o
);
  import pax_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned PW = W + F + 2;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned RW = AW - F;

  localparam logic signed [AW-1:0] RND = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [RW-1:0] HI  = RW'($signed({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [RW-1:0] LO  = RW'($signed({1'b1, {(W-1){1'b0}}}));

  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] r;
  logic                 over;
  logic                 under;

  // Exact products and their sum with the rounding half
  assign p0  = PW'(a_i) * PW'(ca_i);
  assign p1  = PW'(b_i) * PW'(cb_i);
  assign acc = AW'(p0) + AW'(p1) + RND;

  // Drop the fraction bits (floor), then clip to the coordinate range
  assign r     = $signed(acc[AW-1:F]);
  assign over  = (r > HI);
  assign under = (r < LO);

  assign res_o  = over ? HI[W-1:0] : (under ? LO[W-1:0] : r[W-1:0]);
  assign clip_o = over | under;

endmodule

// File: rtl/core/point_axis_rotator.sv
// Top level of the point axis rotator: handshake, pipeline registers and axis selection.
//
//   channel  dir  handshake        payload
//   cfg_i    in   valid / ready    rotation_axis (0: about X, 1: about Y)
//   in_i     in   valid / ready    in_x, in_y, in_z, angle_deg
//   out_o    out  valid / ready    out_x, out_y, out_z, saturated
//
// Result valid rises once the point has passed from the input register into the result register;
// one point per cycle is sustained while out_o.ready stays high, set by the input register
// and the result register around one multiply-add-round-saturate pass.
// Reset clears the valid flags and selects rotation about X.
// A stalled result holds in the result register while one more point waits in the
// input register; ready drops only when both are full and out_o.ready is low.
module point_axis_rotator #(
  parameter int unsigned COORD_WIDTH    = pax_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = pax_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pax_cfg_if.sink       cfg_i,
  pax_point_if.sink     in_i,
  pax_result_if.source  out_o
);
  import pax_pkg::*;

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;

  // Configuration register
  logic axis_q;

  // Input stage
  logic                          in_valid_q;
  logic                          in_valid_d;
  logic signed [COORD_WIDTH-1:0] x_q;
  logic signed [COORD_WIDTH-1:0] y_q;
  logic signed [COORD_WIDTH-1:0] z_q;
  logic [ANGLE_WIDTH-1:0]        ang_q;

  // Result stage
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic signed [COORD_WIDTH-1:0] ox_q;
  logic signed [COORD_WIDTH-1:0] ox_d;
  logic signed [COORD_WIDTH-1:0] oy_q;
  logic signed [COORD_WIDTH-1:0] oy_d;
  logic signed [COORD_WIDTH-1:0] oz_q;
  logic signed [COORD_WIDTH-1:0] oz_d;
  logic                          sat_q;
  logic                          sat_d;

  logic in_take;
  logic stage_adv;

  logic signed [TW-1:0]          sin_v;
  logic signed [TW-1:0]          nsin_v;
  logic signed [TW-1:0]          cos_v;
  logic signed [COORD_WIDTH-1:0] lane_a_src;
  logic signed [TW-1:0]          lane_a_cz;
  logic signed [TW-1:0]          lane_b_cx;
  logic signed [COORD_WIDTH-1:0] lane_a_res;
  logic signed [COORD_WIDTH-1:0] lane_b_res;
  logic                          lane_a_clip;
  logic                          lane_b_clip;

  // Accept configuration at any time; keep bit 0 only
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_X;
    end else if (cfg_i.valid && cfg_i.ready) begin
      axis_q <= cfg_i.rotation_axis;
    end
  end

  // Pipeline flow control
  assign stage_adv   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || stage_adv;
  assign in_take     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_take ? 1'b1 : (stage_adv ? 1'b0 : in_valid_q);
  assign out_valid_d = stage_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the point on each input transaction
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q   <= in_i.in_x;
      y_q   <= in_i.in_y;
      z_q   <= in_i.in_z;
      ang_q <= in_i.angle_deg;
    end
  end

  // Sine and cosine of the held angle
  pax_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .angle_i (ang_q),
    .sin_o   (sin_v),
    .nsin_o  (nsin_v),
    .cos_o   (cos_v)
  );

  // Route operands by axis: lane A gives y' (about X) or x' (about Y), lane B gives z'
  assign lane_a_src = (axis_q == AXIS_Y) ? x_q : y_q;
  assign lane_a_cz  = (axis_q == AXIS_Y) ? sin_v : nsin_v;
  assign lane_b_cx  = (axis_q == AXIS_Y) ? nsin_v : sin_v;

  pax_rot_lane #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_a (
    .a_i    (lane_a_src),
    .ca_i   (cos_v),
    .b_i    (z_q),
    .cb_i   (lane_a_cz),
    .res_o  (lane_a_res),
    .clip_o (lane_a_clip)
  );

  pax_rot_lane #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_b (
    .a_i    (lane_a_src),
    .ca_i   (lane_b_cx),
    .b_i    (z_q),
    .cb_i   (cos_v),
    .res_o  (lane_b_res),
    .clip_o (lane_b_clip)
  );

  // Pass the axis coordinate through unchanged
  assign ox_d  = (axis_q == AXIS_Y) ? lane_a_res : x_q;
  assign oy_d  = (axis_q == AXIS_Y) ? y_q : lane_a_res;
  assign oz_d  = lane_b_res;
  assign sat_d = lane_a_clip | lane_b_clip;

  // Load the result register when the input stage advances
  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      oz_q  <= oz_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_x     = ox_q;
  assign out_o.out_y     = oy_q;
  assign out_o.out_z     = oz_q;
  assign out_o.saturated = sat_q;

  // A held point is never dropped while the result side is stalled
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !stage_adv |=> in_valid_q)
    else $error("input stage lost a point while stalled");

  // Every input transaction lands in the input stage
  a_take_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted point not held in input stage");

  // A point moving on always shows up as a result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv |=> out_valid_q)
    else $error("advanced point missing from result stage");

  // A delivered result is not shown again unless a new point moved in
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.ready && !stage_adv |=> !out_valid_q)
    else $error("result repeated after delivery");

endmodule

// File: dv/tb_point_axis_rotator.sv
// Testbench for point_axis_rotator: predicts each rotated point and checks it under handshake pressure.
module tb_point_axis_rotator;
  import pax_pkg::*;

  localparam int unsigned CW         = COORD_WIDTH_DEF;
  localparam int unsigned TFB        = TRIG_FRAC_BITS_DEF;
  localparam int unsigned AW         = ANGLE_WIDTH;
  localparam int          IDLE_LIMIT = 5000;
  localparam int          SETTLE     = 6;
  localparam int          SEG_POINTS = 215;
  localparam int          HOLD_CYCLES = 80;

  // Rotation predictor and queue of expected rotated points
  class rotation_scoreboard;
    typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          sat;
    } rot_result_t;

    longint      sine_q [0:90];
    logic        axis;
    rot_result_t rotated_q [$];
    int          errors;

    function new();
      axis   = AXIS_X;
      errors = 0;
      for (int d = 0; d <= 90; d++) begin
        sine_q[d] = quarter_sine(d);
      end
    endfunction

    // Rounded product in unsigned Q1.31
    function longint unsigned q31_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Taylor series sine of d degrees, 0..90, rounded to TFB fraction bits
    function longint quarter_sine(int d);
      longint unsigned dd;
      longint unsigned rad;
      longint unsigned rad_sq;
      longint unsigned term;
      longint unsigned div;
      longint unsigned half;
      longint          sum;
      dd     = longint'(d);
      rad    = (dd * 64'd6746518852 + 64'd90) / 64'd180;
      rad_sq = q31_mul(rad, rad);
      term   = rad;
      sum    = longint'(rad);
      half   = 64'd1 << (31 - TFB - 1);
      for (int k = 1; k <= 10; k++) begin
        div  = longint'((2 * k) * (2 * k + 1));
        term = q31_mul(term, rad_sq) / div;
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      return longint'(($unsigned(sum) + half) >> (31 - TFB));
    endfunction

    // Mirror the quarter wave into all four quadrants
    function longint sine_of(int a);
      if (a <= 90) return sine_q[a];
      if (a <= 180) return sine_q[180 - a];
      if (a <= 270) return -sine_q[a - 180];
      return -sine_q[360 - a];
    endfunction

    // Round to nearest with ties up, then clip to the coordinate range
    function logic [CW-1:0] round_clip(longint v, inout bit clip);
      longint r;
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      r  = (v + (longint'(1) <<< (TFB - 1))) >>> TFB;
      if (r > hi) begin
        r    = hi;
        clip = 1'b1;
      end else if (r < lo) begin
        r    = lo;
        clip = 1'b1;
      end
      return r[CW-1:0];
    endfunction

    function void set_axis(logic a);
      axis = a;
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction

    // Predict the rotated point for one accepted input transaction
    function void note_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                             logic signed [CW-1:0] pz, logic [AW-1:0] ang);
      longint      x;
      longint      y;
      longint      z;
      longint      s;
      longint      c;
      int          a;
      bit          clip;
      rot_result_t r;
      x    = longint'(px);
      y    = longint'(py);
      z    = longint'(pz);
      a    = int'(ang) % 360;
      s    = sine_of(a);
      c    = sine_of((a + 90) % 360);
      clip = 1'b0;
      if (axis == AXIS_X) begin
        r.x = px;
        r.y = round_clip(y * c - z * s, clip);
        r.z = round_clip(y * s + z * c, clip);
      end else begin
        r.x = round_clip(x * c + z * s, clip);
        r.y = py;
        r.z = round_clip(z * c - x * s, clip);
      end
      r.sat = clip;
      rotated_q = {rotated_q, r};
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [CW-1:0] rx, logic [CW-1:0] ry, logic [CW-1:0] rz,
                               logic rsat);
      rot_result_t e;
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time, rx, ry, rz, rsat);
        errors++;
        return;
      end
      e = rotated_q.pop_front();
      if (rx !== e.x) begin
        $display("%0t: out_x expected %h got %h", $time, e.x, rx);
        errors++;
      end
      if (ry !== e.y) begin
        $display("%0t: out_y expected %h got %h", $time, e.y, ry);
        errors++;
      end
      if (rz !== e.z) begin
        $display("%0t: out_z expected %h got %h", $time, e.z, rz);
        errors++;
      end
      if (rsat !== e.sat) begin
        $display("%0t: saturated expected %b got %b", $time, e.sat, rsat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pax_cfg_if                      cfg_if ();
  pax_point_if  #(.COORD_WIDTH(CW)) pt_if ();
  pax_result_if #(.COORD_WIDTH(CW)) res_if ();

  point_axis_rotator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (pt_if),
    .out_o  (res_if)
  );

  rotation_scoreboard sb;
  int gap_pct;
  int stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int idle_cycles = 0;

  // Generate the clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Record configuration, input and result transactions at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_axis(cfg_if.rotation_axis);
      end
      if (pt_if.valid && pt_if.ready) begin
        sb.note_point(pt_if.in_x, pt_if.in_y, pt_if.in_z, pt_if.angle_deg);
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.out_x, res_if.out_y, res_if.out_z, res_if.saturated);
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((cfg_if.valid && cfg_if.ready) || (pt_if.valid && pt_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drive result ready: random stalls, plus a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    hold_seen    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return {1'b1, {(CW - 1){1'b0}}};
      1:       return {1'b0, {(CW - 1){1'b1}}};
      2:       return '0;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    if ($urandom_range(3) == 0) begin
      return AW'($urandom_range(5) * 90);
    end
    return AW'($urandom_range(511));
  endfunction

  // Offer one point and hold it until accepted
  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [CW-1:0] z, input logic [AW-1:0] ang);
    @(negedge clk_i);
    pt_if.valid     <= 1'b1;
    pt_if.in_x      <= x;
    pt_if.in_y      <= y;
    pt_if.in_z      <= z;
    pt_if.angle_deg <= ang;
    do @(posedge clk_i); while (!pt_if.ready);
  endtask

  // Insert random idle cycles with noise on the payload
  task automatic sender_gap();
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      pt_if.valid     <= 1'b0;
      pt_if.in_x      <= rand_coord();
      pt_if.in_y      <= rand_coord();
      pt_if.in_z      <= rand_coord();
      pt_if.angle_deg <= rand_angle();
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_angle());
      sender_gap();
    end
  endtask

  // Drop valid and wait until every predicted point has come back
  task automatic drain();
    @(negedge clk_i);
    pt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_axis(input logic axis);
    @(negedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.rotation_axis <= axis;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Field extremes, quadrant boundaries, angle wrap and both clip directions
  task automatic run_directed();
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 9'd0);
    send_point(16'h8000, 16'h8000, 16'h8000, DEG_90);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, DEG_180);
    send_point(16'h8000, 16'h7FFF, 16'h8000, DEG_270);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 9'd45);
    send_point(16'h8000, 16'h8000, 16'h8000, 9'd45);
    send_point(16'h0000, 16'h0000, 16'h0000, 9'd359);
    send_point(16'h1234, 16'hEDCB, 16'h0001, DEG_360);
    send_point(16'hFFFF, 16'h0001, 16'hFFFF, 9'd450);
    send_point(16'h2000, 16'h2000, 16'h2000, 9'd511);
    send_point(16'h8000, 16'h7FFF, 16'h7FFF, 9'd135);
    send_point(16'h0001, 16'hFFFF, 16'h8000, 9'd1);
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.rotation_axis = AXIS_X;
    pt_if.valid          = 1'b0;
    pt_if.in_x           = '0;
    pt_if.in_y           = '0;
    pt_if.in_z           = '0;
    pt_if.angle_deg      = '0;
    gap_pct              = 0;
    stall_pct            = 0;
    hold_req             = 0;
    sb                   = new();

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Run the directed list about X from reset, then about Y
    run_directed();
    drain();
    write_axis(AXIS_Y);
    run_directed();
    drain();

    // Hold off the receiver while the sender keeps offering, to fill the block
    hold_req = hold_req + 1;
    send_random(24);
    drain();

    // Sweep idle phases, each under both axes
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      write_axis((seg % 2 == 0) ? AXIS_X : AXIS_Y);
      send_random(SEG_POINTS);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
